>>> hdl/hilbert_curve_index_codec_top_macros.svh
// assertion macros for the hilbert curve index codec
`ifndef HILBERT_CURVE_INDEX_CODEC_TOP_MACROS_SVH
`define HILBERT_CURVE_INDEX_CODEC_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define HCIC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define HCIC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/hcic_pkg.sv
// shared types and constants for the hilbert curve index codec
`timescale 1ns / 1ps

package hcic_pkg;

	localparam int MAX_ORDER_DEF = 16;
	localparam int LVL_PER_STG   = 4;
	localparam int ORDER_W       = 6;
	localparam int CFG_W         = 5;

	localparam logic [CFG_W-1:0] GRID_ORDER_RST = 5'd16;

	localparam logic CMD_ENCODE = 1'b0;
	localparam logic CMD_DECODE = 1'b1;

	typedef struct packed {
		logic        command;
		logic [15:0] coord_y;
		logic [15:0] coord_x;
		logic [31:0] curve_index;
	} in_word_t;

	typedef struct packed {
		logic [31:0] index_out;
		logic [15:0] row_out;
		logic [15:0] col_out;
	} out_word_t;

endpackage

>>> hdl/hilbert_curve_index_codec_top.sv
// top level of the hilbert curve index codec
//
//   channel | dir | handshake            | word
//   in      | in  | in_valid / in_ready  | in_data  (command, coord_y, coord_x, curve_index)
//   out     | out | out_valid/ out_ready | out_data (index_out, row_out, col_out)
//   cfg     | in  | cfg_valid/ cfg_ready | cfg_data (grid_order)
//
// one word in and one word out per cycle when the output is taken
// the path runs through the input register, the level stages and the output register
// each level stage resolves four curve levels, which sets the stage count
// reset clears all valid bits and sets grid_order to 16; no clearing pass
// a stall at the output backs up stage by stage without dropping a word
`timescale 1ns / 1ps

module hilbert_curve_index_codec_top
	import hcic_pkg::*;
#(
	parameter int MAX_ORDER = MAX_ORDER_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_word_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_word_t        out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	`include "hilbert_curve_index_codec_top_macros.svh"

	localparam int CW   = MAX_ORDER;
	localparam int IW   = 2 * MAX_ORDER;
	localparam int NSTG = (MAX_ORDER + LVL_PER_STG - 1) / LVL_PER_STG;

	logic [CFG_W-1:0]   grid_order_q;
	logic [ORDER_W-1:0] order;
	logic [CW-1:0]      cmask;
	logic [IW-1:0]      imask;

	logic          vld_s1;
	logic          cmd_s1;
	logic [CW-1:0] y_s1;
	logic [CW-1:0] x_s1;
	logic [IW-1:0] acc_s1;

	logic [NSTG:0]         v_c;
	logic [NSTG:0]         r_c;
	logic [NSTG:0]         cmd_c;
	logic [NSTG:0][CW-1:0] y_c;
	logic [NSTG:0][CW-1:0] x_c;
	logic [NSTG:0][IW-1:0] acc_c;

	logic      vld_so;
	logic      cmd_so;
	out_word_t res_so;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_order_q <= GRID_ORDER_RST;
		end else if (cfg_valid && cfg_ready) begin
			grid_order_q <= cfg_data;
		end
	end

	assign order = (ORDER_W'(grid_order_q) > ORDER_W'(MAX_ORDER)) ?
		ORDER_W'(MAX_ORDER) : ORDER_W'(grid_order_q);

	always_comb begin
		for (int i = 0; i < CW; i++) begin
			cmask[i] = (i < int'(order));
		end
		for (int j = 0; j < IW; j++) begin
			imask[j] = cmask[j/2];
		end
	end

	// input register, masks to the order in use
	assign in_ready = !vld_s1 || r_c[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= in_data.command;
			y_s1   <= CW'(in_data.coord_y) & cmask;
			x_s1   <= CW'(in_data.coord_x) & cmask;
			acc_s1 <= (in_data.command == CMD_DECODE) ?
				(IW'(in_data.curve_index) & imask) : '0;
		end
	end

	assign v_c[0]   = vld_s1;
	assign cmd_c[0] = cmd_s1;
	assign y_c[0]   = y_s1;
	assign x_c[0]   = x_s1;
	assign acc_c[0] = acc_s1;

	// level stages
	for (genvar g = 0; g < NSTG; g++) begin : g_stage
		hcic_stage #(
			.CW  (CW),
			.IW  (IW),
			.STG (g),
			.LPS (LVL_PER_STG)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.order    (order),
			.up_valid (v_c[g]),
			.up_ready (r_c[g]),
			.up_cmd   (cmd_c[g]),
			.up_y     (y_c[g]),
			.up_x     (x_c[g]),
			.up_acc   (acc_c[g]),
			.dn_valid (v_c[g+1]),
			.dn_ready (r_c[g+1]),
			.dn_cmd   (cmd_c[g+1]),
			.dn_y     (y_c[g+1]),
			.dn_x     (x_c[g+1]),
			.dn_acc   (acc_c[g+1])
		);
	end

	// output register
	assign r_c[NSTG] = !vld_so || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_so <= 1'b0;
		end else if (r_c[NSTG]) begin
			vld_so <= v_c[NSTG];
		end
	end

	always_ff @(posedge clk) begin
		if (r_c[NSTG] && v_c[NSTG]) begin
			cmd_so           <= cmd_c[NSTG];
			res_so.index_out <= (cmd_c[NSTG] == CMD_ENCODE) ? 32'(acc_c[NSTG]) : '0;
			res_so.row_out   <= (cmd_c[NSTG] == CMD_DECODE) ? 16'(y_c[NSTG]) : '0;
			res_so.col_out   <= (cmd_c[NSTG] == CMD_DECODE) ? 16'(x_c[NSTG]) : '0;
		end
	end

	assign out_valid = vld_so;
	assign out_data  = res_so;

	`HCIC_ASSERT_NOW(a_stall_from_out, !in_ready, out_valid && !out_ready, "input stalled without output stall")
	`HCIC_ASSERT_NOW(a_dec_no_index, vld_so && (cmd_so == CMD_DECODE), res_so.index_out == '0, "decode word with nonzero index")
	`HCIC_ASSERT_NOW(a_enc_no_coord, vld_so && (cmd_so == CMD_ENCODE), (res_so.row_out == '0) && (res_so.col_out == '0), "encode word with nonzero coordinates")

endmodule

>>> hdl/hcic_stage.sv
// one pipeline stage of the codec, LPS curve levels per stage
`timescale 1ns / 1ps

module hcic_stage
	import hcic_pkg::*;
#(
	parameter int CW  = MAX_ORDER_DEF,
	parameter int IW  = 2 * MAX_ORDER_DEF,
	parameter int STG = 0,
	parameter int LPS = LVL_PER_STG
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [ORDER_W-1:0] order,
	input  logic               up_valid,
	output logic               up_ready,
	input  logic               up_cmd,
	input  logic [CW-1:0]      up_y,
	input  logic [CW-1:0]      up_x,
	input  logic [IW-1:0]      up_acc,
	output logic               dn_valid,
	input  logic               dn_ready,
	output logic               dn_cmd,
	output logic [CW-1:0]      dn_y,
	output logic [CW-1:0]      dn_x,
	output logic [IW-1:0]      dn_acc
);

	logic          vld_sn;
	logic          cmd_sn;
	logic [CW-1:0] y_sn;
	logic [CW-1:0] x_sn;
	logic [IW-1:0] acc_sn;

	logic [CW-1:0] y_nx;
	logic [CW-1:0] x_nx;
	logic [IW-1:0] acc_nx;

	always_comb begin
		int step;
		logic rx;
		logic ry;
		logic [CW-1:0] t;
		logic [CW-1:0] sm;
		y_nx   = up_y;
		x_nx   = up_x;
		acc_nx = up_acc;
		rx     = 1'b0;
		ry     = 1'b0;
		t      = '0;
		sm     = '0;
		for (int k = 0; k < LPS; k++) begin
			step = STG * LPS + k;
			if (step < CW) begin
				if (up_cmd == CMD_ENCODE) begin
					// top level first
					if ((CW - 1 - step) < int'(order)) begin
						ry = y_nx[CW-1-step];
						rx = x_nx[CW-1-step];
						acc_nx[2*(CW-1-step) +: 2] = {rx, rx ^ ry};
						if (!ry) begin
							if (rx) begin
								y_nx = ~y_nx;
								x_nx = ~x_nx;
							end
							t    = x_nx;
							x_nx = y_nx;
							y_nx = t;
						end
					end
				end else begin
					// bottom level first
					if (step < int'(order)) begin
						sm = (CW'(1) << step) - CW'(1);
						rx = acc_nx[2*step+1];
						ry = acc_nx[2*step] ^ rx;
						if (!ry) begin
							if (rx) begin
								y_nx = y_nx ^ sm;
								x_nx = x_nx ^ sm;
							end
							t    = x_nx;
							x_nx = y_nx;
							y_nx = t;
						end
						x_nx[step] = rx;
						y_nx[step] = ry;
					end
				end
			end
		end
	end

	assign up_ready = !vld_sn || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= 1'b0;
		end else if (up_ready) begin
			vld_sn <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			cmd_sn <= up_cmd;
			y_sn   <= y_nx;
			x_sn   <= x_nx;
			acc_sn <= acc_nx;
		end
	end

	assign dn_valid = vld_sn;
	assign dn_cmd   = cmd_sn;
	assign dn_y     = y_sn;
	assign dn_x     = x_sn;
	assign dn_acc   = acc_sn;

endmodule
